FILE: src/sfps8_pkg.sv
`default_nettype none

package sfps8_pkg;

	// Word widths on the stream ports.
	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned MDataW = 40;
	localparam int unsigned MUserW = 2;

	// Frame layout constants.
	localparam logic [ByteW-1:0] SYNC_A         = 8'h55;
	localparam logic [ByteW-1:0] SYNC_B         = 8'hAA;
	localparam logic [ByteW-1:0] REPORT_CMD     = 8'd5;
	localparam logic [LenW-1:0]  REPORT_MIN_LEN = 16'd18;
	localparam logic [LenW-1:0]  IDX_STATE      = 16'd4;
	localparam logic [LenW-1:0]  IDX_BATTERY    = 16'd17;

	// Bit positions of the result flags in m_tuser.
	localparam int unsigned USER_OK  = 0;
	localparam int unsigned USER_REP = 1;

endpackage

`default_nettype wire

FILE: src/serial_frame_parser_sum8.sv
`default_nettype none

// Length-prefixed serial frame parser with an 8-bit running-sum checksum. Each
// input word is one received byte. A frame is 0x55, 0xAA, a version byte, a
// command byte, a big-endian 16-bit length, that many data bytes and a checksum
// byte equal to the wrapping 8-bit sum of every byte before it. Exactly one
// result word leaves per checksum byte, good or bad; all other bytes produce
// nothing. The block takes one byte in every cycle while its result side is
// not stalled: the byte goes into an input register, the parse logic works
// on it in the next cycle and a result lands in the output register. The
// whole path advances whenever the output register is empty or being read,
// so a stalled result holds the input side until it is taken. Data bytes 4
// and 17 are captured on the fly as the contact state and battery level;
// they are reported (and otherwise zero) when the frame is good, its command
// is 5 and its length is at least 18.
module serial_frame_parser_sum8
	import sfps8_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [ByteW-1:0]  s_tdata,   // [7:0] rx_byte
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [MDataW-1:0]      m_tdata,   // [7:0] command, [23:8] payload_length,
	                                          // [31:24] contact_state, [39:32] battery_level
	output logic [MUserW-1:0]      m_tuser    // [0] frame_ok, [1] report_valid
);

	// Parser phases.
	localparam logic [2:0] PH_SYNC0 = 3'd0;
	localparam logic [2:0] PH_SYNC1 = 3'd1;
	localparam logic [2:0] PH_VER   = 3'd2;
	localparam logic [2:0] PH_CMD   = 3'd3;
	localparam logic [2:0] PH_LENH  = 3'd4;
	localparam logic [2:0] PH_LENL  = 3'd5;
	localparam logic [2:0] PH_DATA  = 3'd6;
	localparam logic [2:0] PH_CHK   = 3'd7;

	// The whole pipe moves when the output register can take a new value.
	logic advance;
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	// Input register.
	logic             in_valid_s1;
	logic [ByteW-1:0] in_byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (advance) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	// Parser state.
	logic [2:0]       phase_q,   phase_d;
	logic [ByteW-1:0] sum_q,     sum_d;
	logic [ByteW-1:0] cmd_q,     cmd_d;
	logic [LenW-1:0]  len_q,     len_d;
	logic [LenW-1:0]  cnt_q,     cnt_d;
	logic [ByteW-1:0] contact_q, contact_d;
	logic [ByteW-1:0] battery_q, battery_d;

	logic [ByteW-1:0] sum_add;
	logic [LenW-1:0]  len_full;
	logic [LenW-1:0]  cnt_inc;
	logic             emit;
	logic             ok;
	logic             rep;

	assign sum_add  = sum_q + in_byte_s1;
	assign len_full = {len_q[ByteW-1:0], in_byte_s1};
	assign cnt_inc  = cnt_q + 16'd1;
	assign emit     = in_valid_s1 && (phase_q == PH_CHK);
	assign ok       = (sum_q == in_byte_s1);
	assign rep      = ok && (cmd_q == REPORT_CMD) && (len_q >= REPORT_MIN_LEN);

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		contact_d = contact_q;
		battery_d = battery_q;
		case (phase_q)
			PH_SYNC0: begin
				// Anything but the first sync byte is skipped while hunting.
				if (in_byte_s1 == SYNC_A) begin
					sum_d   = in_byte_s1;
					phase_d = PH_SYNC1;
				end
			end
			PH_SYNC1: begin
				// A wrong second sync byte is consumed and the hunt restarts.
				if (in_byte_s1 == SYNC_B) begin
					sum_d   = sum_add;
					phase_d = PH_VER;
				end else begin
					phase_d = PH_SYNC0;
				end
			end
			PH_VER: begin
				sum_d   = sum_add;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				sum_d     = sum_add;
				cmd_d     = in_byte_s1;
				len_d     = '0;
				contact_d = '0;
				battery_d = '0;
				phase_d   = PH_LENH;
			end
			PH_LENH: begin
				sum_d   = sum_add;
				len_d   = {{(LenW-ByteW){1'b0}}, in_byte_s1};
				cnt_d   = '0;
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				// An empty payload goes straight to the checksum byte.
				sum_d   = sum_add;
				len_d   = len_full;
				cnt_d   = '0;
				phase_d = (len_full == '0) ? PH_CHK : PH_DATA;
			end
			PH_DATA: begin
				sum_d = sum_add;
				if (cnt_q == IDX_STATE) begin
					contact_d = in_byte_s1;
				end
				if (cnt_q == IDX_BATTERY) begin
					battery_d = in_byte_s1;
				end
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				phase_d = PH_SYNC0;
			end
			default: begin
				phase_d = PH_SYNC0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC0;
			sum_q     <= '0;
			cmd_q     <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			contact_q <= '0;
			battery_q <= '0;
		end else if (advance && in_valid_s1) begin
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			contact_q <= contact_d;
			battery_q <= battery_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_tdata  <= {rep ? battery_q : {ByteW{1'b0}},
			             rep ? contact_q : {ByteW{1'b0}},
			             len_q, cmd_q};
			m_tuser  <= {rep, ok};
		end
	end

endmodule

`default_nettype wire

FILE: src/sfps8_checker.sv
`default_nettype none

module sfps8_checker
	import sfps8_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic [ByteW-1:0]  s_tdata,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [MDataW-1:0] m_tdata,
	input wire logic [MUserW-1:0] m_tuser
);

	// A byte that is offered and not taken stays on the bus unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while stalled");

	// A result that is not taken holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A report is only raised on a good frame.
	a_rep_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_REP] |-> m_tuser[USER_OK])
		else $error("report on a bad frame");

	// A report needs the report command and a long enough payload.
	a_rep_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_REP] |->
			(m_tdata[7:0] == REPORT_CMD) && (m_tdata[23:8] >= REPORT_MIN_LEN))
		else $error("report with wrong command or short length");

	// Without a report the captured bytes read as zero.
	a_no_rep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[USER_REP] |-> (m_tdata[39:24] == '0))
		else $error("captured bytes not cleared without a report");

endmodule

bind serial_frame_parser_sum8 sfps8_checker u_sfps8_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/sfps8_tb_pkg.sv
`timescale 1ns / 100ps

package sfps8_tb_pkg;

	import sfps8_pkg::*;

	// Where the parser stands within a frame.
	typedef enum logic [2:0] {
		HUNT_SYNC_A,
		HUNT_SYNC_B,
		TAKE_VERSION,
		TAKE_COMMAND,
		TAKE_LEN_HI,
		TAKE_LEN_LO,
		TAKE_DATA,
		TAKE_CHECKSUM
	} parse_phase_t;

	// One result word as the parser should emit it.
	typedef struct {
		logic             ok;
		logic [ByteW-1:0] command;
		logic [LenW-1:0]  length;
		logic             report;
		logic [ByteW-1:0] contact;
		logic [ByteW-1:0] battery;
	} frame_verdict_t;

	// Tracks the byte stream the way the parser must, and keeps the verdicts
	// of completed frames until the matching result words come out.
	class frame_scoreboard;
		parse_phase_t     phase;
		logic [ByteW-1:0] running_sum;
		logic [ByteW-1:0] command;
		logic [LenW-1:0]  length;
		logic [LenW-1:0]  data_index;
		logic [ByteW-1:0] contact;
		logic [ByteW-1:0] battery;
		frame_verdict_t   awaited_verdicts[$];
		int unsigned      mismatches;
		int unsigned      words_checked;
		int unsigned      good_frames;
		int unsigned      reports;

		function new();
			phase = HUNT_SYNC_A;
			running_sum = '0;
			command = '0;
			length = '0;
			data_index = '0;
			contact = '0;
			battery = '0;
			mismatches = 0;
			words_checked = 0;
			good_frames = 0;
			reports = 0;
		endfunction

		function int unsigned outstanding();
			return awaited_verdicts.size();
		endfunction

		// Called for every byte the parser accepts.
		function void note_byte(logic [ByteW-1:0] b);
			frame_verdict_t v;
			case (phase)
				HUNT_SYNC_A: begin
					if (b == SYNC_A) begin
						running_sum = b;
						phase = HUNT_SYNC_B;
					end
				end
				HUNT_SYNC_B: begin
					// A wrong byte here is swallowed, even when it is itself 0x55.
					if (b == SYNC_B) begin
						running_sum += b;
						phase = TAKE_VERSION;
					end else begin
						phase = HUNT_SYNC_A;
					end
				end
				TAKE_VERSION: begin
					running_sum += b;
					phase = TAKE_COMMAND;
				end
				TAKE_COMMAND: begin
					running_sum += b;
					command = b;
					length = '0;
					contact = '0;
					battery = '0;
					phase = TAKE_LEN_HI;
				end
				TAKE_LEN_HI: begin
					running_sum += b;
					length = {8'h00, b};
					data_index = '0;
					phase = TAKE_LEN_LO;
				end
				TAKE_LEN_LO: begin
					running_sum += b;
					length = {length[7:0], b};
					data_index = '0;
					phase = (length == '0) ? TAKE_CHECKSUM : TAKE_DATA;
				end
				TAKE_DATA: begin
					running_sum += b;
					if (data_index == IDX_STATE)
						contact = b;
					if (data_index == IDX_BATTERY)
						battery = b;
					data_index++;
					if (data_index == length)
						phase = TAKE_CHECKSUM;
				end
				TAKE_CHECKSUM: begin
					v.ok = (running_sum == b);
					v.command = command;
					v.length = length;
					v.report = v.ok && command == REPORT_CMD && length >= REPORT_MIN_LEN;
					v.contact = v.report ? contact : '0;
					v.battery = v.report ? battery : '0;
					awaited_verdicts.push_back(v);
					phase = HUNT_SYNC_A;
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Called for every result word the parser hands over.
		function void check_word(logic [MDataW-1:0] data, logic [MUserW-1:0] user);
			frame_verdict_t v;
			if (awaited_verdicts.size() == 0) begin
				$error("result word with no frame outstanding: tdata %h, tuser %b",
					data, user);
				mismatches++;
				return;
			end
			v = awaited_verdicts.pop_front();
			words_checked++;
			compare_field("frame_ok", 32'(v.ok), 32'(user[USER_OK]));
			compare_field("command", 32'(v.command), 32'(data[7:0]));
			compare_field("payload_length", 32'(v.length), 32'(data[23:8]));
			compare_field("report_valid", 32'(v.report), 32'(user[USER_REP]));
			compare_field("contact_state", 32'(v.contact), 32'(data[31:24]));
			compare_field("battery_level", 32'(v.battery), 32'(data[39:32]));
			if (v.ok)
				good_frames++;
			if (v.report)
				reports++;
		endfunction
	endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	import sfps8_pkg::*;
	import sfps8_tb_pkg::*;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned RandomBytes = 500;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ByteW-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [MDataW-1:0] m_tdata;
	logic [MUserW-1:0] m_tuser;

	frame_scoreboard sb = new();

	int unsigned cycles = 0;
	int unsigned framed_bytes = 0;
	bit          tx_calm = 1'b1;
	bit          rx_calm = 1'b0;
	int unsigned rx_stall = 0;

	serial_frame_parser_sum8 i_dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tuser
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("** serial_frame_parser_sum8: FAILED **");
			$finish;
		end
	end

	// Result side: take a word, then hold tready low for a random stretch.
	// Calm stretches with tready held high come and go at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_word(m_tdata, m_tuser);
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			rx_stall = rx_calm ? 0 : $urandom_range(0, 8);
		end
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one byte and returns at the edge where it is taken; tvalid stays
	// high so that a following byte can go out in the very next cycle.
	task automatic send_byte(input logic [ByteW-1:0] b);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
	endtask

	// A complete frame with random version and payload; a bad frame gets its
	// checksum knocked off by a nonzero amount.
	task automatic send_frame(input logic [ByteW-1:0] cmd, input logic [LenW-1:0] len,
			input bit good);
		logic [ByteW-1:0] sum;
		logic [ByteW-1:0] b;
		sum = SYNC_A + SYNC_B;
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		b = 8'($urandom_range(0, 255));
		sum += b;
		send_byte(b);
		sum += cmd;
		send_byte(cmd);
		sum += len[15:8];
		send_byte(len[15:8]);
		sum += len[7:0];
		send_byte(len[7:0]);
		for (int unsigned i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			sum += b;
			send_byte(b);
		end
		if (!good)
			sum += 8'($urandom_range(1, 255));
		send_byte(sum);
		framed_bytes += 7 + len;
	endtask

	// Drops tvalid and waits for every outstanding result word.
	task automatic hold_off();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		logic [ByteW-1:0] cmd;
		logic [LenW-1:0]  len;
		logic [ByteW-1:0] b;
		int unsigned      pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes while hunting are ignored, 0xAA included.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_B);
		// A repeated 0x55 is the wrong second sync byte and is swallowed, so
		// the 0xAA after it falls on a hunting parser.
		send_byte(SYNC_A);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		// Zero length goes straight to the checksum.
		send_frame(8'hFF, 16'd0, 1'b1);
		// Shortest frame that carries a report.
		tx_calm = 1'b0;
		send_frame(REPORT_CMD, REPORT_MIN_LEN, 1'b1);
		hold_off();

		while (framed_bytes < RandomBytes) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// Line noise, kept clear of 0x55 so the next frame still lines up.
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					send_byte((b == SYNC_A) ? SYNC_B : b);
				end
			end else if (pick == 1) begin
				b = 8'($urandom_range(0, 255));
				send_byte(SYNC_A);
				send_byte((b == SYNC_B) ? SYNC_A : b);
				framed_bytes += 2;
			end else begin
				cmd = ($urandom_range(0, 1) == 0) ? REPORT_CMD : 8'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: len = 16'd0;
					1, 2, 3: len = 16'($urandom_range(16, 20));
					default: len = 16'($urandom_range(1, 30));
				endcase
				send_frame(cmd, len, $urandom_range(0, 4) != 0);
			end
			if ($urandom_range(0, 39) == 0)
				hold_off();
		end

		// One report frame whose length uses the high byte, sent back to back.
		tx_calm = 1'b1;
		send_frame(REPORT_CMD, 16'h0113, 1'b1);

		hold_off();
		repeat (8) @(posedge clk);

		$display("Checked %0d result words after %0d framed bytes and noise.",
			sb.words_checked, framed_bytes);
		$display("%0d frames had a good checksum and %0d carried a report.",
			sb.good_frames, sb.reports);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("** serial_frame_parser_sum8: PASSED **");
		end else begin
			$display("** serial_frame_parser_sum8: FAILED **");
		end
		$finish;
	end

endmodule
